[rtl/wildcard_byte_pattern_scan_core_defines.svh]
// Assertion macros for the wildcard byte pattern scan core
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wbps_pkg.sv]
// Shared constants and types for the wildcard byte pattern scan core
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int OFFSET_BITS       = 32;

  localparam int WIN_W      = 8 * MAX_PATTERN_BYTES;
  localparam int NIB_N      = 2 * MAX_PATTERN_BYTES;
  localparam int LEN_W      = 4;
  localparam int FILL_W     = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int OUT_OFF_W  = 32;
  localparam int OUT_DATA_W = OUT_OFF_W + 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_CARE    = 2'd1,
    REG_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

[rtl/wildcard_byte_pattern_scan_core.sv]
// Wildcard byte pattern scan core: windowed nibble-masked compare over a byte stream
//
// Takes one stream byte per cycle on the in_ channel and, when the newest
// pattern_length bytes match the pattern (nibbles with a clear care bit are
// wildcards), gives one transfer on the out_ channel carrying the offset of
// the first matched byte and the matched bytes. Bytes that do not complete a
// match give no transfer. The result is registered, shown in the cycle after
// its input transfer; throughput is one byte per cycle, held back only when a
// result waits on out_tready, since the single result register is the only
// buffer. in_tlast marks the final byte of a stream, after which window and
// offset restart at zero. The offset saturates at its maximum. Registers must
// be written through cfg_ only while the block is idle, which it does not enforce.
`default_nettype none
`include "wildcard_byte_pattern_scan_core_defines.svh"

module wildcard_byte_pattern_scan_core
  import wbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] data_byte
  input  wire logic                  in_tlast,   // end_of_stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [31:0] match_offset, [95:32] matched_bytes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [WIN_W-1:0]       pattern_r;
  logic [NIB_N-1:0]       care_r;
  logic [LEN_W-1:0]       length_r;

  byte_t                  window_r [MAX_PATTERN_BYTES];
  byte_t                  window_nxt [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0]      filled_r, filled_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic                   in_fire;
  logic [FILL_W-1:0]      len_eff;
  logic [WIN_W-1:0]       seen;
  logic [WIN_W-1:0]       seen_masked;
  logic [NIB_N-1:0]       nib_hit;
  logic                   match;
  logic [OFFSET_BITS-1:0] offset;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '1;
      length_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN: pattern_r <= cfg_wdata[WIN_W-1:0];
        REG_CARE:    care_r    <= cfg_wdata[NIB_N-1:0];
        REG_LENGTH:  length_r  <= cfg_wdata[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // shifted window and counters as they stand after this byte
  always_comb begin
    window_nxt[0] = in_tdata;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_nxt[i] = window_r[i-1];
    end
    filled_nxt = (filled_r < FILL_W'(MAX_PATTERN_BYTES)) ? filled_r + FILL_W'(1) : filled_r;
    pos_nxt    = (pos_r != '1) ? pos_r + OFFSET_BITS'(1) : pos_r;
  end

  assign len_eff = (length_r > LEN_W'(MAX_PATTERN_BYTES)) ?
                   FILL_W'(MAX_PATTERN_BYTES) : FILL_W'(length_r);

  // nibble compare over the newest len_eff bytes
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      seen[8*k +: 8]        = window_nxt[k];
      seen_masked[8*k +: 8] = (k < int'(len_eff)) ? window_nxt[k] : 8'h00;
    end
    for (int j = 0; j < NIB_N; j++) begin
      nib_hit[j] = !care_r[j] || (j >= 2 * int'(len_eff)) ||
                   (seen[4*j +: 4] == pattern_r[4*j +: 4]);
    end
  end

  assign match  = (len_eff != '0) && (filled_nxt >= len_eff) && (&nib_hit);
  assign offset = pos_r - OFFSET_BITS'(len_eff - FILL_W'(1));

  // stream state; clear after the last byte of a stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        window_r[i] <= '0;
      end
      filled_r <= '0;
      pos_r    <= '0;
    end else if (in_fire) begin
      if (in_tlast) begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
          window_r[i] <= '0;
        end
        filled_r <= '0;
        pos_r    <= '0;
      end else begin
        window_r <= window_nxt;
        filled_r <= filled_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && match) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && match) begin
      out_data_r <= {seen_masked, OUT_OFF_W'(offset)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WBPS_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_tready, !in_tready, "input taken while result stalled")
  `WBPS_ASSERT_NEXT(a_last_clears, in_fire && in_tlast, (filled_r == '0) && (pos_r == '0), "stream state not cleared after last byte")
  `WBPS_ASSERT_NOW(a_fill_bound, 1'b1, filled_r <= FILL_W'(MAX_PATTERN_BYTES), "fill count beyond window depth")
  `WBPS_ASSERT_NEXT(a_pos_moves, in_fire && !in_tlast, pos_r != '0, "byte position did not advance")
  `WBPS_ASSERT_NEXT(a_result_needs_fire, !out_valid_r && !(in_fire && match), !out_valid_r, "result without a matching transfer")

endmodule

`default_nettype wire
